[rtl/tgd_pkg.sv]
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared constants, types and zone functions for the thumbstick gesture
// decoder.
// ----------------------------------------------------------------------------
package tgd_pkg;

  // table sizes
  localparam int unsigned GLYPHS  = 32;
  localparam int unsigned STROKES = 5;

  // field widths
  localparam int unsigned ANGLE_W  = 12;
  localparam int unsigned ACT_W    = 32;
  localparam int unsigned HOLD_W   = 10;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned PAT_W    = CODE_W * STROKES;
  localparam int unsigned PAT_IN_W = 15;
  localparam int unsigned CFG_W    = 10;

  // derived counter and address widths
  localparam int unsigned GCNT_W  = $clog2(GLYPHS + 1);
  localparam int unsigned GADDR_W = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
  localparam int unsigned SCNT_W  = $clog2(STROKES + 1);
  localparam int unsigned SIDX_W  = (STROKES > 1) ? $clog2(STROKES) : 1;

  // wheel table: index is direction * 4 + button
  localparam int unsigned WHEEL_DEPTH = 32;
  localparam int unsigned WHEEL_AW    = 5;

  // request codes
  localparam logic [1:0] REQ_STICK = 2'd0;
  localparam logic [1:0] REQ_GLYPH = 2'd1;
  localparam logic [1:0] REQ_WHEEL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESH     = 2'd0;
  localparam logic [1:0] CFG_GLYPH_HOLD = 2'd1;
  localparam logic [1:0] CFG_WHEEL_HOLD = 2'd2;

  // configuration reset values
  localparam logic [THR_W-1:0]  THRESH_RST     = THR_W'(179);
  localparam logic [HOLD_W-1:0] GLYPH_HOLD_RST = HOLD_W'(100);
  localparam logic [HOLD_W-1:0] WHEEL_HOLD_RST = HOLD_W'(10);

  // stroke codes
  localparam logic [CODE_W-1:0] STROKE_LEFT  = 3'd1;
  localparam logic [CODE_W-1:0] STROKE_RIGHT = 3'd2;
  localparam logic [CODE_W-1:0] STROKE_UP    = 3'd3;
  localparam logic [CODE_W-1:0] STROKE_DOWN  = 3'd4;

  // button indexes
  localparam logic [1:0] BTN_A = 2'd0;
  localparam logic [1:0] BTN_B = 2'd1;
  localparam logic [1:0] BTN_X = 2'd2;
  localparam logic [1:0] BTN_Y = 2'd3;

  // zone edges in 1/8 degree
  localparam logic signed [ANGLE_W-1:0] Z22  = ANGLE_W'(180);
  localparam logic signed [ANGLE_W-1:0] Z45  = ANGLE_W'(360);
  localparam logic signed [ANGLE_W-1:0] Z67  = ANGLE_W'(540);
  localparam logic signed [ANGLE_W-1:0] Z112 = ANGLE_W'(900);
  localparam logic signed [ANGLE_W-1:0] Z135 = ANGLE_W'(1080);
  localparam logic signed [ANGLE_W-1:0] Z157 = ANGLE_W'(1260);

  // glyph table write port
  typedef struct packed {
    logic               en;
    logic [GADDR_W-1:0] addr;
    logic [PAT_W-1:0]   pattern;
    logic [ACT_W-1:0]   action;
  } tgd_glyph_wr_t;

  // glyph search outcome
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [ACT_W-1:0] action;
  } tgd_scan_res_t;

  // 4-way zone, lower edge inclusive, upper edge exclusive
  function automatic logic [CODE_W-1:0] zone4(input logic signed [ANGLE_W-1:0] a);
    logic [CODE_W-1:0] z;
    if (a >= -Z135 && a < -Z45)      z = STROKE_LEFT;
    else if (a >= Z45 && a < Z135)   z = STROKE_RIGHT;
    else if (a >= -Z45 && a <= Z45)  z = STROKE_UP;
    else                             z = STROKE_DOWN;
    return z;
  endfunction

  // 8-way zone, 0 up then clockwise, everything left over is down
  function automatic logic [2:0] zone8(input logic signed [ANGLE_W-1:0] a);
    logic [2:0] z;
    if (a >= -Z22 && a < Z22)         z = 3'd0;
    else if (a >= Z22 && a < Z67)     z = 3'd1;
    else if (a >= Z67 && a < Z112)    z = 3'd2;
    else if (a >= Z112 && a < Z157)   z = 3'd3;
    else if (a >= -Z157 && a < -Z112) z = 3'd5;
    else if (a >= -Z112 && a < -Z67)  z = 3'd6;
    else if (a >= -Z67 && a < -Z22)   z = 3'd7;
    else                              z = 3'd4;
    return z;
  endfunction

endpackage

[rtl/tgd_ram.sv]
// ----------------------------------------------------------------------------
// tgd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tgd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tgd_glyph_scan.sv]
// ----------------------------------------------------------------------------
// tgd_glyph_scan
// Glyph table storage and a sequential search that walks the loaded entries
// one per cycle through a single pattern comparator.
// ----------------------------------------------------------------------------
module tgd_glyph_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tgd_pkg::tgd_glyph_wr_t        wr_i,
  input  logic                          start_i,
  input  logic [tgd_pkg::PAT_W-1:0]     key_i,
  input  logic [tgd_pkg::GCNT_W-1:0]    count_i,
  output tgd_pkg::tgd_scan_res_t        res_o
);
  import tgd_pkg::*;

  logic                     busy_q, busy_d;
  logic                     cmp_q, cmp_d;
  logic [GCNT_W-1:0]        idx_q, idx_d;
  logic [PAT_W-1:0]         key_q, key_d;
  logic                     done_q, done_d;
  logic                     hit_q, hit_d;
  logic [ACT_W-1:0]         act_q, act_d;
  logic                     issue;
  logic                     match;
  logic                     finish;
  logic [ACT_W+PAT_W-1:0]   rd_word;

  // glyph entries: action above pattern
  tgd_ram #(
    .Width(ACT_W + PAT_W),
    .Depth(GLYPHS)
  ) u_glyph_ram (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.addr),
    .wdata_i({wr_i.action, wr_i.pattern}),
    .re_i   (issue),
    .raddr_i(idx_q[GADDR_W-1:0]),
    .rdata_o(rd_word)
  );

  // compare the entry read last cycle, issue the next read
  always_comb begin
    match  = cmp_q && (rd_word[PAT_W-1:0] == key_q);
    finish = busy_q && (match || (!cmp_q && !(idx_q < count_i)));
    issue  = busy_q && !finish && (idx_q < count_i);

    busy_d = busy_q;
    cmp_d  = issue;
    idx_d  = idx_q;
    key_d  = key_q;
    done_d = finish;
    hit_d  = match;
    act_d  = act_q;

    if (issue) begin
      idx_d = idx_q + GCNT_W'(1);
    end
    if (finish) begin
      busy_d = 1'b0;
      act_d  = rd_word[ACT_W+PAT_W-1:PAT_W];
    end
    if (start_i) begin
      busy_d = 1'b1;
      cmp_d  = 1'b0;
      idx_d  = '0;
      key_d  = key_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cmp_q  <= 1'b0;
      idx_q  <= '0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cmp_q  <= cmp_d;
      idx_q  <= idx_d;
      done_q <= done_d;
      hit_q  <= hit_d;
    end
  end

  // search key and matched action
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    act_q <= act_d;
  end

  assign res_o.done   = done_q;
  assign res_o.hit    = hit_q;
  assign res_o.action = act_q;

endmodule

[rtl/thumbstick_gesture_decoder.sv]
// ----------------------------------------------------------------------------
// thumbstick_gesture_decoder
// Sorts stick samples into stroke and wheel zones, fires wheel actions and
// matches stroke sequences against a loaded glyph table on release.
// ----------------------------------------------------------------------------
// Items are taken one at a time; a glyph or wheel load keeps the block in
// the idle state. A deflected stick sample passes through the done state,
// after the wheel state when a button is held (one wheel table read). A
// release after strokes, unless a wheel action fired, walks the glyph table
// one entry per cycle through its single read port and comparator. Results
// sit in an output register, so a load can be taken while one is pending.
module thumbstick_gesture_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic signed [tgd_pkg::ANGLE_W-1:0] angle_i,
  input  logic [7:0]                       radius_i,
  input  logic                             btn_a_i,
  input  logic                             btn_b_i,
  input  logic                             btn_x_i,
  input  logic                             btn_y_i,
  input  logic [tgd_pkg::PAT_IN_W-1:0]     pattern_i,
  input  logic [tgd_pkg::ACT_W-1:0]        action_code_i,
  input  logic [2:0]                       wheel_dir_i,
  input  logic [1:0]                       wheel_button_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             fire_o,
  output logic [tgd_pkg::ACT_W-1:0]        action_out_o,
  output logic [tgd_pkg::HOLD_W-1:0]       hold_time_o,
  output logic                             abxy_enable_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [tgd_pkg::CFG_W-1:0]        cfg_data_i
);
  import tgd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WHEEL = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [THR_W-1:0]                thr_q, thr_d;
  logic [HOLD_W-1:0]               ghold_q, ghold_d;
  logic [HOLD_W-1:0]               whold_q, whold_d;
  logic [STROKES-1:0][CODE_W-1:0]  strokes_q, strokes_d;
  logic [CODE_W-1:0]               last_q, last_d;
  logic [SCNT_W-1:0]               scnt_q, scnt_d;
  logic                            wused_q, wused_d;
  logic                            abxy_q, abxy_d;
  logic [GCNT_W-1:0]               gcnt_q, gcnt_d;
  logic [WHEEL_DEPTH-1:0]          wvalid_q, wvalid_d;
  logic                            wval_q, wval_d;
  logic                            res_fire_q, res_fire_d;
  logic [ACT_W-1:0]                res_act_q, res_act_d;
  logic [HOLD_W-1:0]               res_hold_q, res_hold_d;
  logic                            out_vld_q, out_vld_d;
  logic                            out_fire_q, out_fire_d;
  logic [ACT_W-1:0]                out_act_q, out_act_d;
  logic [HOLD_W-1:0]               out_hold_q, out_hold_d;
  logic                            out_abxy_q, out_abxy_d;

  logic                            in_acc;
  logic                            is_stick;
  logic                            defl;
  logic [CODE_W-1:0]               d4;
  logic [2:0]                      d8;
  logic                            btn_any;
  logic [1:0]                      bsel;
  logic                            out_xfer;
  logic                            scan_start;
  logic                            wheel_we;
  logic                            wheel_re;
  logic [WHEEL_AW-1:0]             wheel_waddr;
  logic [WHEEL_AW-1:0]             wheel_raddr;
  logic [ACT_W-1:0]                wheel_rdata;
  tgd_glyph_wr_t                   gwr;
  tgd_scan_res_t                   scan_res;

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_xfer    = out_vld_q && !out_stall_i;
  assign is_stick    = (req_type_i == REQ_STICK);

  // sample classification
  assign defl    = (radius_i > thr_q);
  assign d4      = zone4(angle_i);
  assign d8      = zone8(angle_i);
  assign btn_any = btn_a_i | btn_b_i | btn_x_i | btn_y_i;

  // first pressed button wins
  always_comb begin
    if (btn_a_i)      bsel = BTN_A;
    else if (btn_b_i) bsel = BTN_B;
    else if (btn_x_i) bsel = BTN_X;
    else              bsel = BTN_Y;
  end

  // table port requests
  assign gwr.en      = in_acc && (req_type_i == REQ_GLYPH) && (gcnt_q < GCNT_W'(GLYPHS));
  assign gwr.addr    = gcnt_q[GADDR_W-1:0];
  assign gwr.pattern = pattern_i[PAT_W-1:0];
  assign gwr.action  = action_code_i;
  assign wheel_we    = in_acc && (req_type_i == REQ_WHEEL);
  assign wheel_waddr = {wheel_dir_i, wheel_button_i};
  assign wheel_re    = in_acc && is_stick && defl && btn_any;
  assign wheel_raddr = {d8, bsel};
  assign scan_start  = in_acc && is_stick && !defl && (scnt_q != '0) && !wused_q;

  // wheel action table
  tgd_ram #(
    .Width(ACT_W),
    .Depth(WHEEL_DEPTH)
  ) u_wheel_ram (
    .clk_i  (clk_i),
    .we_i   (wheel_we),
    .waddr_i(wheel_waddr),
    .wdata_i(action_code_i),
    .re_i   (wheel_re),
    .raddr_i(wheel_raddr),
    .rdata_o(wheel_rdata)
  );

  // glyph table and search
  tgd_glyph_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (gwr),
    .start_i(scan_start),
    .key_i  (strokes_q),
    .count_i(gcnt_q),
    .res_o  (scan_res)
  );

  // sequencer and gesture state
  always_comb begin
    state_d    = state_q;
    thr_d      = thr_q;
    ghold_d    = ghold_q;
    whold_d    = whold_q;
    strokes_d  = strokes_q;
    last_d     = last_q;
    scnt_d     = scnt_q;
    wused_d    = wused_q;
    abxy_d     = abxy_q;
    gcnt_d     = gcnt_q;
    wvalid_d   = wvalid_q;
    wval_d     = wval_q;
    res_fire_d = res_fire_q;
    res_act_d  = res_act_q;
    res_hold_d = res_hold_q;
    out_vld_d  = out_vld_q;
    out_fire_d = out_fire_q;
    out_act_d  = out_act_q;
    out_hold_d = out_hold_q;
    out_abxy_d = out_abxy_q;

    // register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESH:     thr_d   = cfg_data_i[THR_W-1:0];
        CFG_GLYPH_HOLD: ghold_d = cfg_data_i[HOLD_W-1:0];
        CFG_WHEEL_HOLD: whold_d = cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end

    if (out_xfer) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_GLYPH: begin
              if (gwr.en) begin
                gcnt_d = gcnt_q + GCNT_W'(1);
              end
            end
            REQ_WHEEL: begin
              wvalid_d[wheel_waddr] = 1'b1;
            end
            REQ_STICK: begin
              res_fire_d = 1'b0;
              res_act_d  = '0;
              res_hold_d = '0;
              state_d    = S_DONE;
              if (defl) begin
                abxy_d = 1'b0;
                // append a stroke when room is left and it is the first or the zone changed
                if (scnt_q < SCNT_W'(STROKES) && (scnt_q == '0 || d4 != last_q)) begin
                  strokes_d[scnt_q[SIDX_W-1:0]] = d4;
                  last_d = d4;
                  scnt_d = scnt_q + SCNT_W'(1);
                end
                if (btn_any) begin
                  wused_d = 1'b1;
                  wval_d  = wvalid_q[wheel_raddr];
                  state_d = S_WHEEL;
                end
              end else if (scnt_q != '0) begin
                // release: search unless a wheel action fired
                if (!wused_q) begin
                  state_d = S_SCAN;
                end
                strokes_d = '0;
                scnt_d    = '0;
                wused_d   = 1'b0;
                abxy_d    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WHEEL: begin
        res_fire_d = 1'b1;
        res_act_d  = wval_q ? wheel_rdata : '0;
        res_hold_d = whold_q;
        state_d    = S_DONE;
      end
      S_SCAN: begin
        if (scan_res.done) begin
          res_fire_d = scan_res.hit;
          res_act_d  = scan_res.hit ? scan_res.action : '0;
          res_hold_d = scan_res.hit ? ghold_q : '0;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        // move the result into the output register once it is free
        if (!out_vld_q || out_xfer) begin
          out_vld_d  = 1'b1;
          out_fire_d = res_fire_q;
          out_act_d  = res_act_q;
          out_hold_d = res_hold_q;
          out_abxy_d = abxy_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      thr_q     <= THRESH_RST;
      ghold_q   <= GLYPH_HOLD_RST;
      whold_q   <= WHEEL_HOLD_RST;
      strokes_q <= '0;
      scnt_q    <= '0;
      wused_q   <= 1'b0;
      abxy_q    <= 1'b1;
      gcnt_q    <= '0;
      wvalid_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      thr_q     <= thr_d;
      ghold_q   <= ghold_d;
      whold_q   <= whold_d;
      strokes_q <= strokes_d;
      scnt_q    <= scnt_d;
      wused_q   <= wused_d;
      abxy_q    <= abxy_d;
      gcnt_q    <= gcnt_d;
      wvalid_q  <= wvalid_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    wval_q     <= wval_d;
    res_fire_q <= res_fire_d;
    res_act_q  <= res_act_d;
    res_hold_q <= res_hold_d;
    out_fire_q <= out_fire_d;
    out_act_q  <= out_act_d;
    out_hold_q <= out_hold_d;
    out_abxy_q <= out_abxy_d;
  end

  assign out_valid_o   = out_vld_q;
  assign fire_o        = out_fire_q;
  assign action_out_o  = out_act_q;
  assign hold_time_o   = out_hold_q;
  assign abxy_enable_o = out_abxy_q;

  // a result that does not fire carries no action and no hold time
  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fire_o |-> action_out_o == '0 && hold_time_o == '0)
    else $error("result without fire carries an action");

  // stroke count stays within the stroke buffer
  a_stroke_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= SCNT_W'(STROKES))
    else $error("stroke count overflow");

  // a wheel action only fires while strokes are held
  a_wheel_strokes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wused_q |-> scnt_q != '0)
    else $error("wheel flag set without strokes");

  // a released stick leaves no strokes behind
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_stick && !defl |=> scnt_q == '0 && !wused_q)
    else $error("strokes not cleared on release");

  // the search only reports back while the sequencer waits for it
  a_scan_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> state_q == S_SCAN)
    else $error("glyph search finished outside its wait state");

endmodule

[test/thumbstick_gesture_decoder_checker.sv]
// ----------------------------------------------------------------------------
// thumbstick_gesture_decoder_checker
// Watches the item, result and register channels of the gesture decoder,
// keeps its own copy of the stroke, glyph and wheel state, and compares
// every result transfer field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module thumbstick_gesture_decoder_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [1:0]                          req_type_i,
  input  logic signed [tgd_pkg::ANGLE_W-1:0]  angle_i,
  input  logic [7:0]                          radius_i,
  input  logic                                btn_a_i,
  input  logic                                btn_b_i,
  input  logic                                btn_x_i,
  input  logic                                btn_y_i,
  input  logic [tgd_pkg::PAT_IN_W-1:0]        pattern_i,
  input  logic [tgd_pkg::ACT_W-1:0]           action_code_i,
  input  logic [2:0]                          wheel_dir_i,
  input  logic [1:0]                          wheel_button_i,
  // result channel
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                fire_i,
  input  logic [tgd_pkg::ACT_W-1:0]           action_out_i,
  input  logic [tgd_pkg::HOLD_W-1:0]          hold_time_i,
  input  logic                                abxy_enable_i,
  // register writes
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [tgd_pkg::CFG_W-1:0]           cfg_data_i,
  // status to the testbench top
  output int unsigned                         mismatch_count_o,
  output int unsigned                         pending_count_o
);

  import tgd_pkg::*;

  // zone edges in 1/8 degree
  localparam int EDGE_22  = 180;
  localparam int EDGE_45  = 360;
  localparam int EDGE_67  = 540;
  localparam int EDGE_112 = 900;
  localparam int EDGE_135 = 1080;
  localparam int EDGE_157 = 1260;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic              fire;
    logic [ACT_W-1:0]  action;
    logic [HOLD_W-1:0] hold;
    logic              abxy;
  } report_t;

  // register copies
  logic [THR_W-1:0]  thresh_q;
  logic [HOLD_W-1:0] glyph_hold_q;
  logic [HOLD_W-1:0] wheel_hold_q;

  // gesture state
  logic [CODE_W-1:0] stroke_seq [STROKES];
  int unsigned       stroke_num;
  bit                wheel_fired;
  bit                abxy_state;

  // tables
  int unsigned       glyph_num;
  logic [PAT_W-1:0]  glyph_pat [GLYPHS];
  logic [ACT_W-1:0]  glyph_act [GLYPHS];
  logic [ACT_W-1:0]  wheel_tab [WHEEL_DEPTH];

  report_t           expected_reports [$];
  int unsigned       mismatches;

  // 4-way stroke zone, tests in order, lower edge inclusive
  function automatic logic [CODE_W-1:0] stroke_dir(input int a);
    if (a >= -EDGE_135 && a < -EDGE_45) return STROKE_LEFT;
    if (a >= EDGE_45 && a < EDGE_135) return STROKE_RIGHT;
    if (a >= -EDGE_45 && a <= EDGE_45) return STROKE_UP;
    return STROKE_DOWN;
  endfunction

  // 8-way wheel sector, anything left over is down
  function automatic logic [2:0] wheel_sector(input int a);
    if (a >= -EDGE_22 && a < EDGE_22) return 3'd0;
    if (a >= EDGE_22 && a < EDGE_67) return 3'd1;
    if (a >= EDGE_67 && a < EDGE_112) return 3'd2;
    if (a >= EDGE_112 && a < EDGE_157) return 3'd3;
    if (a >= -EDGE_157 && a < -EDGE_112) return 3'd5;
    if (a >= -EDGE_112 && a < -EDGE_67) return 3'd6;
    if (a >= -EDGE_67 && a < -EDGE_22) return 3'd7;
    return 3'd4;
  endfunction

  // apply one accepted item, returns 1 when it yields a report
  function automatic bit decode_item(output report_t rep);
    int                a;
    int                i;
    int                j;
    logic [CODE_W-1:0] dir4;
    logic [2:0]        dir8;
    logic [1:0]        btn;
    bit                pressed;
    logic [PAT_W-1:0]  seq_word;
    rep = '0;
    case (req_type_i)
      REQ_GLYPH: begin
        if (glyph_num < GLYPHS) begin
          glyph_pat[glyph_num] = pattern_i[PAT_W-1:0];
          glyph_act[glyph_num] = action_code_i;
          glyph_num++;
        end
        return 1'b0;
      end
      REQ_WHEEL: begin
        wheel_tab[{wheel_dir_i, wheel_button_i}] = action_code_i;
        return 1'b0;
      end
      REQ_STICK: ;
      default: return 1'b0;
    endcase

    a = int'(angle_i);
    if (radius_i > thresh_q) begin
      // deflected: maybe a new stroke, maybe a wheel action
      dir4 = stroke_dir(a);
      dir8 = wheel_sector(a);
      abxy_state = 1'b0;
      if (stroke_num < STROKES &&
          (stroke_num == 0 || dir4 != stroke_seq[stroke_num-1])) begin
        stroke_seq[stroke_num] = dir4;
        stroke_num++;
      end
      pressed = 1'b1;
      if (btn_a_i) btn = BTN_A;
      else if (btn_b_i) btn = BTN_B;
      else if (btn_x_i) btn = BTN_X;
      else if (btn_y_i) btn = BTN_Y;
      else begin
        btn = BTN_A;
        pressed = 1'b0;
      end
      if (pressed) begin
        rep.fire   = 1'b1;
        rep.action = wheel_tab[{dir8, btn}];
        rep.hold   = wheel_hold_q;
        wheel_fired = 1'b1;
      end
    end else if (stroke_num > 0) begin
      // release after strokes: first matching glyph unless the wheel fired
      if (!wheel_fired) begin
        seq_word = '0;
        for (j = 0; j < STROKES; j++) seq_word[CODE_W*j +: CODE_W] = stroke_seq[j];
        for (i = 0; i < glyph_num; i++) begin
          if (glyph_pat[i] == seq_word) begin
            rep.fire   = 1'b1;
            rep.action = glyph_act[i];
            rep.hold   = glyph_hold_q;
            break;
          end
        end
      end
      for (j = 0; j < STROKES; j++) stroke_seq[j] = '0;
      stroke_num  = 0;
      wheel_fired = 1'b0;
      abxy_state  = 1'b1;
    end
    rep.abxy = abxy_state;
    return 1'b1;
  endfunction

  // compare result transfers, then predict from item transfers
  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t got;
    report_t want;
    report_t fresh;
    int      k;
    if (!rst_ni) begin
      thresh_q     = THRESH_RST;
      glyph_hold_q = GLYPH_HOLD_RST;
      wheel_hold_q = WHEEL_HOLD_RST;
      for (k = 0; k < STROKES; k++) stroke_seq[k] = '0;
      stroke_num  = 0;
      wheel_fired = 1'b0;
      abxy_state  = 1'b1;
      glyph_num   = 0;
      for (k = 0; k < GLYPHS; k++) begin
        glyph_pat[k] = '0;
        glyph_act[k] = '0;
      end
      for (k = 0; k < WHEEL_DEPTH; k++) wheel_tab[k] = '0;
      expected_reports.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{fire: fire_i, action: action_out_i, hold: hold_time_i,
                abxy: abxy_enable_i};
        if (expected_reports.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result with none expected: fire %0b action %h hold %0d abxy %0b",
                     $time, got.fire, got.action, got.hold, got.abxy);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $write("%0t: result mismatch: expected fire %0b action %h hold %0d abxy %0b,",
                     $time, want.fire, want.action, want.hold, want.abxy);
              $display(" got fire %0b action %h hold %0d abxy %0b",
                       got.fire, got.action, got.hold, got.abxy);
            end
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (decode_item(fresh)) expected_reports.push_back(fresh);
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_THRESH:     thresh_q     = cfg_data_i[THR_W-1:0];
          CFG_GLYPH_HOLD: glyph_hold_q = cfg_data_i[HOLD_W-1:0];
          CFG_WHEEL_HOLD: wheel_hold_q = cfg_data_i[HOLD_W-1:0];
          default: ;
        endcase
      end

      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_reports.size();
    end
  end

endmodule

[test/thumbstick_gesture_decoder_tb.sv]
// ----------------------------------------------------------------------------
// thumbstick_gesture_decoder_tb
// Drives the gesture decoder with directed edge cases, then with phases of
// random gestures, table loads and noise under several register settings,
// with random gaps and result stalls. The checker beside the block does the
// prediction and comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module thumbstick_gesture_decoder_tb;

  import tgd_pkg::*;

  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned IDLE_PERCENT  = 20;

  typedef struct {
    logic [1:0]                req;
    logic signed [ANGLE_W-1:0] ang;
    logic [7:0]                rad;
    logic [3:0]                btn;  // y x b a
    logic [PAT_IN_W-1:0]       pat;
    logic [ACT_W-1:0]          act;
    logic [2:0]                wdir;
    logic [1:0]                wbtn;
  } item_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                req_type_i;
  logic signed [ANGLE_W-1:0] angle_i;
  logic [7:0]                radius_i;
  logic                      btn_a_i;
  logic                      btn_b_i;
  logic                      btn_x_i;
  logic                      btn_y_i;
  logic [PAT_IN_W-1:0]       pattern_i;
  logic [ACT_W-1:0]          action_code_i;
  logic [2:0]                wheel_dir_i;
  logic [1:0]                wheel_button_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      fire_o;
  logic [ACT_W-1:0]          action_out_o;
  logic [HOLD_W-1:0]         hold_time_o;
  logic                      abxy_enable_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i;
  logic [CFG_W-1:0]          cfg_data_i;

  int unsigned         mismatches;
  int unsigned         pending_results;
  int unsigned         quiet_cycles = 0;
  bit                  calm;
  logic [THR_W-1:0]    cur_thresh;
  int unsigned         items_sent;
  int unsigned         glyph_loads;
  logic [PAT_IN_W-1:0] known_glyphs [$];

  thumbstick_gesture_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .angle_i        (angle_i),
    .radius_i       (radius_i),
    .btn_a_i        (btn_a_i),
    .btn_b_i        (btn_b_i),
    .btn_x_i        (btn_x_i),
    .btn_y_i        (btn_y_i),
    .pattern_i      (pattern_i),
    .action_code_i  (action_code_i),
    .wheel_dir_i    (wheel_dir_i),
    .wheel_button_i (wheel_button_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fire_o         (fire_o),
    .action_out_o   (action_out_o),
    .hold_time_o    (hold_time_o),
    .abxy_enable_o  (abxy_enable_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  thumbstick_gesture_decoder_checker gesture_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .angle_i          (angle_i),
    .radius_i         (radius_i),
    .btn_a_i          (btn_a_i),
    .btn_b_i          (btn_b_i),
    .btn_x_i          (btn_x_i),
    .btn_y_i          (btn_y_i),
    .pattern_i        (pattern_i),
    .action_code_i    (action_code_i),
    .wheel_dir_i      (wheel_dir_i),
    .wheel_button_i   (wheel_button_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fire_i           (fire_o),
    .action_out_i     (action_out_o),
    .hold_time_i      (hold_time_o),
    .abxy_enable_i    (abxy_enable_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending_results)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side stalls at random unless calm
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("thumbstick_gesture_decoder test failed");
    $finish;
  end

  // fully random item, any request code
  function automatic item_t noise_item();
    item_t it;
    it.req  = 2'($urandom_range(0, 3));
    it.ang  = ANGLE_W'($urandom);
    it.rad  = 8'($urandom);
    it.btn  = 4'($urandom);
    it.pat  = PAT_IN_W'($urandom);
    it.act  = $urandom;
    it.wdir = 3'($urandom);
    it.wbtn = 2'($urandom);
    return it;
  endfunction

  function automatic item_t stick_item(input logic signed [ANGLE_W-1:0] ang,
                                       input logic [7:0] rad, input logic [3:0] btn);
    item_t it;
    it     = noise_item();
    it.req = REQ_STICK;
    it.ang = ang;
    it.rad = rad;
    it.btn = btn;
    return it;
  endfunction

  function automatic item_t wheel_item(input logic [2:0] dir, input logic [1:0] btn,
                                       input logic [ACT_W-1:0] act);
    item_t it;
    it      = noise_item();
    it.req  = REQ_WHEEL;
    it.wdir = dir;
    it.wbtn = btn;
    it.act  = act;
    return it;
  endfunction

  // angle somewhere inside the zone of a stroke code
  function automatic logic signed [ANGLE_W-1:0] angle_for(input logic [CODE_W-1:0] code);
    case (code)
      STROKE_UP:    return ANGLE_W'(-360 + int'($urandom_range(0, 719)));
      STROKE_RIGHT: return ANGLE_W'(360 + int'($urandom_range(0, 719)));
      STROKE_LEFT:  return ANGLE_W'(-1080 + int'($urandom_range(0, 719)));
      default: begin
        if ($urandom_range(0, 1)) return ANGLE_W'(1080 + int'($urandom_range(0, 967)));
        return ANGLE_W'(-2048 + int'($urandom_range(0, 967)));
      end
    endcase
  endfunction

  function automatic logic [7:0] deflect_radius();
    if (cur_thresh == 8'hFF) return 8'hFF;
    return 8'($urandom_range(int'(cur_thresh) + 1, 255));
  endfunction

  function automatic logic [7:0] rest_radius();
    return 8'($urandom_range(0, int'(cur_thresh)));
  endfunction

  // 1 to STROKES strokes, neighbors always differ
  function automatic logic [PAT_IN_W-1:0] random_gesture();
    logic [PAT_IN_W-1:0] pat;
    logic [CODE_W-1:0]   c;
    logic [CODE_W-1:0]   last;
    int                  n;
    int                  k;
    pat  = '0;
    last = '0;
    n    = $urandom_range(1, STROKES);
    for (k = 0; k < n; k++) begin
      do c = CODE_W'($urandom_range(STROKE_LEFT, STROKE_DOWN)); while (c == last);
      pat[CODE_W*k +: CODE_W] = c;
      last = c;
    end
    return pat;
  endfunction

  // one item transfer, with random gaps before it
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= it.req;
    angle_i        <= it.ang;
    radius_i       <= it.rad;
    btn_a_i        <= it.btn[0];
    btn_b_i        <= it.btn[1];
    btn_x_i        <= it.btn[2];
    btn_y_i        <= it.btn[3];
    pattern_i      <= it.pat;
    action_code_i  <= it.act;
    wheel_dir_i    <= it.wdir;
    wheel_button_i <= it.wbtn;
    do @(posedge clk_i); while (in_stall_o);
    if (it.req != REQ_UNUSED) items_sent++;
  endtask

  task automatic load_glyph(input logic [PAT_IN_W-1:0] pat, input logic [ACT_W-1:0] act,
                            input bit playable);
    item_t it;
    it     = noise_item();
    it.req = REQ_GLYPH;
    it.pat = pat;
    it.act = act;
    send_item(it);
    if (playable && glyph_loads < GLYPHS) known_glyphs.push_back(pat);
    glyph_loads++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold off the sender until every result is back and the block is quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // strokes of a pattern, each held a few samples, then a release
  task automatic play_gesture(input logic [PAT_IN_W-1:0] pat);
    logic [CODE_W-1:0] codes [$];
    logic [CODE_W-1:0] c;
    int                wheel_at;
    int                k;
    int                r;
    for (k = 0; k < STROKES; k++) begin
      c = pat[CODE_W*k +: CODE_W];
      if (c == '0) break;
      codes.push_back(c);
    end
    // sometimes one stroke too many
    if ($urandom_range(0, 9) == 0) begin
      do c = CODE_W'($urandom_range(STROKE_LEFT, STROKE_DOWN));
      while (codes.size() > 0 && c == codes[$]);
      codes.push_back(c);
    end
    wheel_at = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, codes.size() - 1)) : -1;
    for (k = 0; k < codes.size(); k++) begin
      for (r = $urandom_range(1, 3); r > 0; r--)
        send_item(stick_item(angle_for(codes[k]), deflect_radius(),
                             (k == wheel_at) ? 4'($urandom_range(1, 15)) : 4'b0000));
    end
    send_item(stick_item(ANGLE_W'($urandom), rest_radius(), 4'($urandom)));
  endtask

  // one register setting followed by random traffic
  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [HOLD_W-1:0] g_hold,
                           input logic [HOLD_W-1:0] w_hold, input int unsigned quota,
                           input bit no_gaps, input bit mid_pause);
    int unsigned start;
    int unsigned r;
    bit          paused;
    int          k;
    settle();
    write_reg(CFG_THRESH, {2'($urandom), thr});
    write_reg(CFG_GLYPH_HOLD, g_hold);
    write_reg(CFG_WHEEL_HOLD, w_hold);
    cur_thresh = thr;
    calm <= no_gaps;
    paused = 1'b0;
    for (k = 0; k < 6; k++) load_glyph(random_gesture(), $urandom, 1'b1);
    for (k = 0; k < 2; k++) send_item(wheel_item(3'($urandom), 2'($urandom), $urandom));
    start = items_sent;
    while (items_sent - start < quota) begin
      if (mid_pause && !paused && items_sent - start >= quota / 2) begin
        settle();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if (known_glyphs.size() > 0 && $urandom_range(0, 1))
          play_gesture(known_glyphs[$urandom_range(0, known_glyphs.size() - 1)]);
        else
          play_gesture(random_gesture());
      end else if (r < 63) begin
        load_glyph(PAT_IN_W'($urandom), $urandom, 1'b0);
      end else if (r < 68) begin
        load_glyph(random_gesture(), $urandom, 1'b1);
      end else if (r < 71 && known_glyphs.size() > 0) begin
        // same pattern again, the first entry must win
        load_glyph(known_glyphs[$urandom_range(0, known_glyphs.size() - 1)], $urandom, 1'b0);
      end else if (r < 81) begin
        send_item(wheel_item(3'($urandom), 2'($urandom), $urandom));
      end else begin
        send_item(noise_item());
      end
    end
    calm <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    item_t blank;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_STICK;
    angle_i        = '0;
    radius_i       = '0;
    btn_a_i        = 1'b0;
    btn_b_i        = 1'b0;
    btn_x_i        = 1'b0;
    btn_y_i        = 1'b0;
    pattern_i      = '0;
    action_code_i  = '0;
    wheel_dir_i    = '0;
    wheel_button_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_THRESH;
    cfg_data_i     = '0;
    calm           = 1'b0;
    cur_thresh     = THRESH_RST;
    items_sent     = 0;
    glyph_loads    = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unknown request with every bit set
    blank = '{req: REQ_UNUSED, ang: '1, rad: '1, btn: '1, pat: '1, act: '1,
              wdir: '1, wbtn: '1};
    send_item(blank);
    // release without strokes, and a radius right at the threshold
    send_item(stick_item(12'sd0, 8'd0, 4'b0000));
    send_item(stick_item(12'sd2047, 8'd179, 4'b0101));
    // table loads at value extremes
    send_item(wheel_item(3'd4, BTN_A, 32'hFFFF_FFFF));
    send_item(wheel_item(3'd4, BTN_Y, 32'h0F0F_0F0F));
    send_item(wheel_item(3'd7, BTN_X, 32'h0000_0000));
    load_glyph(PAT_IN_W'({STROKE_RIGHT, STROKE_UP}), 32'h1234_5678, 1'b1);
    load_glyph(15'h7FFF, 32'hFFFF_FFFF, 1'b0);
    load_glyph(15'h0000, 32'h0000_0000, 1'b0);
    load_glyph({STROKE_UP, STROKE_RIGHT, STROKE_DOWN, STROKE_UP, STROKE_LEFT},
               32'h8000_0001, 1'b1);
    // up, right, release: glyph match
    send_item(stick_item(12'sd0, 8'd180, 4'b0000));
    send_item(stick_item(12'sd360, 8'd255, 4'b0000));
    send_item(stick_item(-12'sd100, 8'd179, 4'b0000));
    // beyond half a turn with buttons: wheel fires, repeat, then no glyph
    send_item(stick_item(-12'sd2048, 8'd255, 4'b1111));
    send_item(stick_item(12'sd2047, 8'd255, 4'b1000));
    send_item(stick_item(12'sd0, 8'd0, 4'b0000));
    // zone edges up to the stroke limit, extra strokes dropped
    send_item(stick_item(-12'sd1080, 8'd200, 4'b0000));
    send_item(stick_item(-12'sd360, 8'd200, 4'b0000));
    send_item(stick_item(12'sd1080, 8'd200, 4'b0000));
    send_item(stick_item(-12'sd1081, 8'd200, 4'b0000));
    send_item(stick_item(12'sd360, 8'd200, 4'b0000));
    send_item(stick_item(-12'sd180, 8'd200, 4'b0000));
    send_item(stick_item(12'sd1440, 8'd200, 4'b0000));
    send_item(stick_item(-12'sd1440, 8'd0, 4'b0000));

    // unknown register index, then the random phases
    settle();
    write_reg(CFG_SPARE, CFG_W'($urandom));
    run_phase(8'd0, 10'd1023, 10'd0, 225, 1'b0, 1'b0);
    run_phase(8'd255, 10'd0, 10'd1023, 60, 1'b0, 1'b0);
    run_phase(8'($urandom_range(64, 220)), 10'($urandom), 10'($urandom), 225, 1'b1, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 10'($urandom), 10'($urandom), 225, 1'b0, 1'b1);
    run_phase(8'($urandom_range(100, 200)), 10'($urandom), 10'($urandom), 225, 1'b0, 1'b0);
    settle();

    if (mismatches == 0 && pending_results == 0)
      $display("thumbstick_gesture_decoder test passed");
    else
      $display("thumbstick_gesture_decoder test failed");
    $finish;
  end

endmodule
